@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the hexagonal life block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HL_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("hexlife: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("hexlife: next-cycle check failed");

`endif

@@ src/hexlife_pkg.sv @@
// ----------------------------------------------------------------------------
// hexlife_pkg
// Types, codes and constants shared by the hexagonal life block.
// ----------------------------------------------------------------------------
package hexlife_pkg;

    localparam int FUNC_W = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int LIVE_W = 13;

    localparam logic [LIVE_W-1:0] COUNT_MAX = 13'd8191;

    // Neighbor count that makes a cell live (birth and survival alike).
    localparam logic [2:0] BIRTH_SURVIVE = 3'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_ADVANCE = 2'd2
    } func_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;      // capture request fields, read addressed row
        logic adv_start;  // begin a generation: clear count, read row 0
        logic adv_prime;  // load first row buffer, read row 1
        logic adv_step;   // compute and write one row, advance the buffers
        logic cell_do;    // finish a cell write or read
        logic clr_step;   // clear one row after reset
        logic out_load;   // load the output payload registers
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic seq_last;   // row sequencer sits on the last row
        logic pipe_busy;  // live-count tree still holds rows
    } stat_t;

    // Number of registered levels in a fan-in-8 adder tree over n leaves.
    function automatic int tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = 1;
        for (int i = 0; i < 8; i++) begin
            if (span < n) begin
                span = span * 8;
                lv   = lv + 1;
            end
        end
        return lv;
    endfunction

endpackage

@@ src/hexlife_dp.sv @@
// ----------------------------------------------------------------------------
// hexlife_dp
// Grid memory, three-row window, row update logic and live-count tree.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hexlife_dp
    import hexlife_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             st,
    input  logic [FUNC_W-1:0] func,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic              value,
    output logic              cell_value,
    output logic [LIVE_W-1:0] live_count
);

    localparam int RA_W = $clog2(ROWS);
    localparam int CA_W = $clog2(COLS);
    localparam int CW   = $clog2(COLS + 1);
    localparam int LC_W = $clog2(ROWS * COLS + 1);
    localparam int NG   = (COLS + 7) / 8;
    localparam int PADW = NG * 8;
    localparam int LVLS = tree_levels(NG);

    // Grid storage, one row per word
    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] rd_reg;
    logic            we;
    logic [RA_W-1:0] wa;
    logic [COLS-1:0] wd;
    logic            re;
    logic [RA_W-1:0] ra;

    // Request capture
    logic [FUNC_W-1:0] func_reg;
    logic [RA_W-1:0]   row_reg;
    logic [CA_W-1:0]   col_reg;
    logic              value_reg;
    logic              inside_reg;
    logic              in_inside;
    logic              res_cell_reg;

    // Generation window
    logic [COLS-1:0] prev_reg;
    logic [COLS-1:0] cur_reg;
    logic [COLS-1:0] nxt_row;
    logic [COLS-1:0] new_row;
    logic [RA_W-1:0] seq_reg;
    logic [RA_W:0]   seq_plus1;
    logic [RA_W:0]   seq_plus2;
    logic            nxt_ok;
    logic            rd2_ok;

    // Live-count tree
    logic [COLS-1:0] newrow_reg;
    logic            newrow_vld_reg;
    logic [PADW-1:0] row_pad;
    logic [CW-1:0]   node_reg  [LVLS][NG];
    logic [CW-1:0]   node_next [LVLS][NG];
    logic [LVLS-1:0] vld_reg;

    // Count and outputs
    logic [LC_W-1:0]   live_reg;
    logic [LC_W-1:0]   live_next;
    logic              old_bit;
    logic              cell_wr;
    logic [COLS-1:0]   mod_row;
    logic [LIVE_W-1:0] sat_count;
    logic              cell_value_reg;
    logic [LIVE_W-1:0] live_count_reg;

    assign in_inside = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
    assign seq_plus1 = {1'b0, seq_reg} + (RA_W+1)'(1);
    assign seq_plus2 = {1'b0, seq_reg} + (RA_W+1)'(2);
    assign nxt_ok    = seq_plus1 < (RA_W+1)'(ROWS);
    assign rd2_ok    = seq_plus2 < (RA_W+1)'(ROWS);
    assign nxt_row   = nxt_ok ? rd_reg : '0;
    assign old_bit   = rd_reg[col_reg];
    assign cell_wr   = cmd.cell_do && (func_reg == FUNC_WRITE) && inside_reg;

    always_comb
    begin
        mod_row          = rd_reg;
        mod_row[col_reg] = value_reg;
    end

    // Hex neighborhood: even rows take columns c and c+1 above and below,
    // odd rows take c-1 and c. Padded vectors make the edges read as dead.
    always_comb
    begin
        logic [COLS+1:0] pp;
        logic [COLS+1:0] cp;
        logic [COLS+1:0] np;
        logic [2:0]      n;
        pp = {1'b0, prev_reg, 1'b0};
        cp = {1'b0, cur_reg, 1'b0};
        np = {1'b0, nxt_row, 1'b0};
        for (int c = 0; c < COLS; c++) begin
            n = 3'(cp[c]) + 3'(cp[c+2]);
            if (!seq_reg[0]) begin
                n = n + 3'(pp[c+1]) + 3'(pp[c+2]) + 3'(np[c+1]) + 3'(np[c+2]);
            end
            else begin
                n = n + 3'(pp[c]) + 3'(pp[c+1]) + 3'(np[c]) + 3'(np[c+1]);
            end
            new_row[c] = (n == BIRTH_SURVIVE);
        end
    end

    // Memory port selection
    always_comb
    begin
        we = 1'b0;
        wa = seq_reg;
        wd = '0;
        re = 1'b0;
        ra = seq_reg;
        if (cmd.clr_step) begin
            we = 1'b1;
        end
        if (cmd.adv_step) begin
            we = 1'b1;
            wd = new_row;
            re = rd2_ok;
            ra = RA_W'(seq_plus2);
        end
        if (cell_wr) begin
            we = 1'b1;
            wa = row_reg;
            wd = mod_row;
        end
        if (cmd.latch) begin
            if (cmd.adv_start) begin
                re = 1'b1;
                ra = '0;
            end
            else begin
                re = in_inside;
                ra = RA_W'(row);
            end
        end
        if (cmd.adv_prime) begin
            re = 1'b1;
            ra = RA_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_reg <= mem[ra];
        end
    end

    // Fan-in-8 live-count tree, one register level per stage
    assign row_pad = PADW'(newrow_reg);

    always_comb
    begin
        logic [CW-1:0] sum;
        for (int i = 0; i < NG; i++) begin
            sum = '0;
            for (int j = 0; j < 8; j++) begin
                sum = sum + CW'(row_pad[i*8+j]);
            end
            node_next[0][i] = sum;
        end
        for (int l = 1; l < LVLS; l++) begin
            for (int i = 0; i < NG; i++) begin
                sum = '0;
                for (int j = 0; j < 8; j++) begin
                    if (i * 8 + j < NG) begin
                        sum = sum + node_reg[l-1][i*8+j];
                    end
                end
                node_next[l][i] = sum;
            end
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (cmd.adv_start) begin
            live_next = '0;
        end
        else if (vld_reg[LVLS-1]) begin
            live_next = live_reg + LC_W'(node_reg[LVLS-1][0]);
        end
        else if (cell_wr && (old_bit != value_reg)) begin
            live_next = value_reg ? live_reg + LC_W'(1) : live_reg - LC_W'(1);
        end
    end

    assign sat_count = (32'(live_reg) > 32'(COUNT_MAX)) ? COUNT_MAX : LIVE_W'(live_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seq_reg        <= '0;
            newrow_vld_reg <= 1'b0;
            vld_reg        <= '0;
            live_reg       <= '0;
        end
        else begin
            if (cmd.adv_start) begin
                seq_reg <= '0;
            end
            else if (cmd.adv_step || cmd.clr_step) begin
                seq_reg <= RA_W'(seq_plus1);
            end
            newrow_vld_reg <= cmd.adv_step;
            vld_reg[0]     <= newrow_vld_reg;
            for (int l = 1; l < LVLS; l++) begin
                vld_reg[l] <= vld_reg[l-1];
            end
            live_reg <= live_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch) begin
            func_reg     <= func;
            row_reg      <= RA_W'(row);
            col_reg      <= CA_W'(col);
            value_reg    <= value;
            inside_reg   <= in_inside;
            res_cell_reg <= 1'b0;
        end
        if (cmd.adv_start) begin
            prev_reg <= '0;
        end
        if (cmd.adv_prime) begin
            cur_reg <= rd_reg;
        end
        if (cmd.adv_step) begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_row;
        end
        if (cmd.cell_do) begin
            if (func_reg == FUNC_WRITE) begin
                res_cell_reg <= inside_reg & value_reg;
            end
            else begin
                res_cell_reg <= inside_reg & old_bit;
            end
        end
        newrow_reg <= new_row;
        node_reg   <= node_next;
        if (cmd.out_load) begin
            cell_value_reg <= res_cell_reg;
            live_count_reg <= sat_count;
        end
    end

    assign st.seq_last  = (seq_reg == RA_W'(ROWS - 1));
    assign st.pipe_busy = newrow_vld_reg | (|vld_reg);
    assign cell_value   = cell_value_reg;
    assign live_count   = live_count_reg;

    `HL_ASSERT_NOW(a_live_bound, clk, rst_n, 1'b1, 32'(live_reg) <= 32'(ROWS * COLS))
    `HL_ASSERT_NEXT(a_adv_clears, clk, rst_n, cmd.adv_start, live_reg == '0)
    `HL_ASSERT_NOW(a_clear_zero, clk, rst_n, cmd.clr_step, live_reg == '0)

endmodule

@@ src/hexlife_ctrl.sv @@
// ----------------------------------------------------------------------------
// hexlife_ctrl
// Sequencer for cell requests, generations, reset clearing and output handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hexlife_ctrl
    import hexlife_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    output logic              out_valid,
    input  logic              out_ready,
    output cmd_t              cmd,
    input  stat_t             st
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CELL  = 7'b0000100,
        ST_PRIME = 7'b0001000,
        ST_RUN   = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.seq_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.latch = 1'b1;
                    case (func)
                        FUNC_WRITE, FUNC_READ:
                        begin
                            state_next = ST_CELL;
                        end
                        FUNC_ADVANCE:
                        begin
                            cmd.adv_start = 1'b1;
                            state_next    = ST_PRIME;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CELL:
            begin
                cmd.cell_do = 1'b1;
                state_next  = ST_DONE;
            end
            ST_PRIME:
            begin
                cmd.adv_prime = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.adv_step = 1'b1;
                if (st.seq_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!st.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    `HL_ASSERT_NEXT(a_run_to_drain, clk, rst_n, state_reg == ST_RUN && st.seq_last, state_reg == ST_DRAIN)
    `HL_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    `HL_ASSERT_NEXT(a_drain_wait, clk, rst_n, state_reg == ST_DRAIN && st.pipe_busy, state_reg == ST_DRAIN)

endmodule

@@ src/hex_life_automaton_step.sv @@
// ----------------------------------------------------------------------------
// hex_life_automaton_step
// Hexagonal life grid (birth and survival on exactly two of six neighbors)
// with cell write, cell read and one-generation advance requests.
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------
//  request   in_valid / in_ready   func, row, col, value
//  result    out_valid/out_ready   cell_value, live_count
//
//  A cell write or read passes the CELL state before its result; func 3
//  goes straight to the result. An advance primes the row window, then
//  one row is written and one read per cycle while a three-row window
//  slides down the grid, and it waits for the live-count tree to drain.
//  Reset: after rst_n releases, a clearing pass writes all ROWS rows dead,
//  one per cycle, and no request is taken during those ROWS cycles.
//  Stalls: a held result stays in the output register; the next request is
//  still taken and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module hex_life_automaton_step
    import hexlife_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FUNC_W-1:0] func,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    input  logic              value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              cell_value,
    output logic [LIVE_W-1:0] live_count
);

    // Commands flow from the sequencer down, status flows back up.
    cmd_t  cmd;
    stat_t st;

    // Sequencer: owns the request/result handshakes and the step order of
    // each request type, plus the post-reset clearing sweep.
    hexlife_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .st        (st)
    );

    // Datapath: grid memory, row window and update logic, live-count tree,
    // request capture and output payload registers.
    hexlife_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .func       (func),
        .row        (row),
        .col        (col),
        .value      (value),
        .cell_value (cell_value),
        .live_count (live_count)
    );

endmodule
